@@ hw/rtl/vrs_pkg.sv @@
// ----------------------------------------------------------------------------
// vrs_pkg
// Shared constants, word types and helpers for the variable record stack.
// ----------------------------------------------------------------------------
`default_nettype none

package vrs_pkg;

	localparam int MEM_BYTES    = 4096;
	localparam int HEADER_BYTES = 4;
	localparam int MAX_RECORD   = 64;
	localparam int ALIGN_BYTES  = 8;

	localparam int ADDR_W     = $clog2(MEM_BYTES);
	localparam int TOP_W      = ADDR_W + 1;
	localparam int SUM_W      = TOP_W + 1;
	localparam int CAP_W      = 13;
	localparam int CMP_W      = ((TOP_W > CAP_W) ? TOP_W : CAP_W) + 1;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 7;
	localparam int SLOT_W     = 8;
	localparam int ALIGN_SH   = $clog2(ALIGN_BYTES);
	localparam int LIDX_DEPTH = MEM_BYTES / ALIGN_BYTES;
	localparam int LIDX_W     = $clog2(LIDX_DEPTH);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index is paddr >> 2
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_EMPTY    = 2'd2;
	localparam logic [1:0] STATUS_LIMIT    = 2'd3;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0]  record_length;
		logic [LEN_W-1:0]  pop_limit;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              is_pop;
		logic [BYTE_W-1:0] out_byte;
		logic [LEN_W-1:0]  out_length;
		logic              byte_valid;
		logic              last;
	} result_t;

	typedef struct packed {
		logic             wr;
		logic [CAP_W-1:0] capacity;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} dram_req_t;

	typedef struct packed {
		logic              we;
		logic [LIDX_W-1:0] waddr;
		logic [LEN_W-1:0]  wdata;
		logic              re;
		logic [LIDX_W-1:0] raddr;
	} lram_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEN,
		ST_STREAM
	} ctrl_state_t;

	// bytes taken by a record: data plus header, rounded up to the alignment
	function automatic logic [SLOT_W-1:0] slot_size(input logic [LEN_W-1:0] len);
		logic [SLOT_W-1:0] s;
		s = SLOT_W'(len) + SLOT_W'(ALIGN_BYTES - 1 + HEADER_BYTES);
		return s & ~SLOT_W'(ALIGN_BYTES - 1);
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vrs_ram.sv @@
// ----------------------------------------------------------------------------
// vrs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module vrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/vrs_apb.sv @@
// ----------------------------------------------------------------------------
// vrs_apb
// APB register slave holding the capacity register; a write to it empties the stack.
// ----------------------------------------------------------------------------
`default_nettype none

module vrs_apb (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [vrs_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [vrs_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [vrs_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready,
	output vrs_pkg::cfg_t                          cfg
);

	logic [vrs_pkg::CAP_W-1:0] capacity_q;
	logic                      reg_sel;
	logic                      wr_en;

	assign reg_sel = (paddr[vrs_pkg::APB_ADDR_W-1] == vrs_pkg::REG_CAPACITY);
	assign wr_en   = psel && penable && pwrite && pready && reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= vrs_pkg::CAP_W'(vrs_pkg::MEM_BYTES);
		end else if (wr_en) begin
			capacity_q <= pwdata[vrs_pkg::CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = reg_sel ? vrs_pkg::APB_DATA_W'(capacity_q) : '0;

	assign cfg.wr       = wr_en;
	assign cfg.capacity = capacity_q;

endmodule

`default_nettype wire

@@ hw/rtl/vrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// vrs_ctrl
// Stack sequencer: push bookkeeping, pop length lookup, byte streaming and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vrs_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire vrs_pkg::cfg_t                cfg,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire vrs_pkg::item_t               item,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output vrs_pkg::result_t                  result,
	output vrs_pkg::dram_req_t                dram,
	input  wire logic [vrs_pkg::BYTE_W-1:0]   dram_rdata,
	output vrs_pkg::lram_req_t                lram,
	input  wire logic [vrs_pkg::LEN_W-1:0]    lram_rdata
);

	vrs_pkg::ctrl_state_t state_q, state_d;

	logic [vrs_pkg::TOP_W-1:0]  stack_top_q, stack_top_d;
	logic [vrs_pkg::LEN_W-1:0]  push_count_q, push_count_d;
	logic                       push_rej_q, push_rej_d;
	logic [vrs_pkg::LEN_W-1:0]  limit_q, limit_d;
	logic [vrs_pkg::LEN_W-1:0]  pop_len_q, pop_len_d;
	logic [vrs_pkg::ADDR_W-1:0] base_q, base_d;
	logic [vrs_pkg::LEN_W-1:0]  idx_q, idx_d;
	logic                       rd_valid_s1, rd_valid_d;
	logic                       rd_last_s1, rd_last_d;
	logic                       out_valid_q, out_valid_d;
	vrs_pkg::result_t           out_q, out_d;
	logic                       out_load;

	logic                       out_free;
	logic                       accept;
	logic [vrs_pkg::TOP_W-1:0]  cap_use;
	logic [vrs_pkg::SLOT_W-1:0] push_slot;
	logic [vrs_pkg::SUM_W-1:0]  push_top;
	logic [vrs_pkg::SUM_W-1:0]  wr_pos;
	logic                       fits;
	logic                       rej;
	logic                       more;
	logic                       over;
	logic [vrs_pkg::SLOT_W-1:0] pop_slot;
	logic [vrs_pkg::TOP_W-1:0]  pop_top;
	logic                       issue;
	logic                       drain;

	assign out_free   = !out_valid_q || result_ready;
	assign item_ready = (state_q == vrs_pkg::ST_IDLE) && !rd_valid_s1 && out_free;
	assign accept     = item_valid && item_ready;

	assign cap_use = (vrs_pkg::CMP_W'(cfg.capacity) > vrs_pkg::CMP_W'(vrs_pkg::MEM_BYTES)) ?
		vrs_pkg::TOP_W'(vrs_pkg::MEM_BYTES) : vrs_pkg::TOP_W'(cfg.capacity);

	// push checks
	assign push_slot = vrs_pkg::slot_size(item.record_length);
	assign push_top  = vrs_pkg::SUM_W'(stack_top_q) + vrs_pkg::SUM_W'(push_slot);
	assign wr_pos    = vrs_pkg::SUM_W'(stack_top_q) + vrs_pkg::SUM_W'(push_count_q);
	assign fits      = (item.record_length <= vrs_pkg::LEN_W'(vrs_pkg::MAX_RECORD)) &&
		(push_top <= vrs_pkg::SUM_W'(cap_use));
	assign rej       = (push_count_q == '0) ? !fits : push_rej_q;
	assign more      = (item.record_length != '0) &&
		((vrs_pkg::LEN_W+1)'(push_count_q) + (vrs_pkg::LEN_W+1)'(1) <
		 (vrs_pkg::LEN_W+1)'(item.record_length));

	// pop checks on the length read back
	assign over     = (limit_q < vrs_pkg::LEN_W'(vrs_pkg::MAX_RECORD)) && (lram_rdata > limit_q);
	assign pop_slot = vrs_pkg::slot_size(lram_rdata);
	assign pop_top  = stack_top_q - vrs_pkg::TOP_W'(pop_slot);

	assign drain = rd_valid_s1 && out_free;
	assign issue = (state_q == vrs_pkg::ST_STREAM) && (!rd_valid_s1 || out_free);

	always_comb begin
		state_d      = state_q;
		stack_top_d  = stack_top_q;
		push_count_d = push_count_q;
		push_rej_d   = push_rej_q;
		limit_d      = limit_q;
		pop_len_d    = pop_len_q;
		base_d       = base_q;
		idx_d        = idx_q;
		rd_valid_d   = drain ? 1'b0 : rd_valid_s1;
		rd_last_d    = rd_last_s1;
		out_load     = 1'b0;
		out_d        = '0;
		dram         = '0;
		lram         = '0;

		dram.wdata = item.data_byte;
		dram.waddr = vrs_pkg::ADDR_W'(wr_pos);
		dram.raddr = base_q + vrs_pkg::ADDR_W'(idx_q);
		lram.waddr = vrs_pkg::LIDX_W'((push_top >> vrs_pkg::ALIGN_SH) - vrs_pkg::SUM_W'(1));
		lram.wdata = item.record_length;
		lram.raddr = vrs_pkg::LIDX_W'((stack_top_q >> vrs_pkg::ALIGN_SH) -
			vrs_pkg::TOP_W'(1));

		unique case (state_q)
			vrs_pkg::ST_IDLE: begin
				if (accept && item.action == vrs_pkg::ACT_PUSH) begin
					dram.we = (item.record_length != '0) && !rej &&
						(wr_pos < vrs_pkg::SUM_W'(cap_use));
					if (more) begin
						push_count_d = push_count_q + vrs_pkg::LEN_W'(1);
						push_rej_d   = rej;
					end else begin
						push_count_d = '0;
						push_rej_d   = 1'b0;
						out_load     = 1'b1;
						out_d.last   = 1'b1;
						if (rej || !fits) begin
							out_d.status = vrs_pkg::STATUS_OVERFLOW;
						end else begin
							out_d.status     = vrs_pkg::STATUS_OK;
							out_d.out_length = item.record_length;
							stack_top_d      = vrs_pkg::TOP_W'(push_top);
							lram.we          = 1'b1;
						end
					end
				end else if (accept) begin
					// a pop abandons any push in progress
					push_count_d = '0;
					push_rej_d   = 1'b0;
					if (stack_top_q == '0) begin
						out_load     = 1'b1;
						out_d.status = vrs_pkg::STATUS_EMPTY;
						out_d.is_pop = 1'b1;
						out_d.last   = 1'b1;
					end else begin
						lram.re = 1'b1;
						limit_d = item.pop_limit;
						state_d = vrs_pkg::ST_LEN;
					end
				end
			end
			vrs_pkg::ST_LEN: begin
				if (over || lram_rdata == '0) begin
					if (out_free) begin
						out_load     = 1'b1;
						out_d.is_pop = 1'b1;
						out_d.last   = 1'b1;
						out_d.status = over ? vrs_pkg::STATUS_LIMIT : vrs_pkg::STATUS_OK;
						if (!over) begin
							stack_top_d = pop_top;
						end
						state_d = vrs_pkg::ST_IDLE;
					end
				end else begin
					stack_top_d = pop_top;
					base_d      = vrs_pkg::ADDR_W'(pop_top);
					pop_len_d   = lram_rdata;
					idx_d       = '0;
					state_d     = vrs_pkg::ST_STREAM;
				end
			end
			vrs_pkg::ST_STREAM: begin
				if (issue) begin
					dram.re    = 1'b1;
					rd_valid_d = 1'b1;
					rd_last_d  = (idx_q + vrs_pkg::LEN_W'(1) == pop_len_q);
					idx_d      = idx_q + vrs_pkg::LEN_W'(1);
					if (idx_q + vrs_pkg::LEN_W'(1) == pop_len_q) begin
						state_d = vrs_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = vrs_pkg::ST_IDLE;
			end
		endcase

		// streamed byte lands in the output register
		if (drain) begin
			out_load         = 1'b1;
			out_d.status     = vrs_pkg::STATUS_OK;
			out_d.is_pop     = 1'b1;
			out_d.out_byte   = dram_rdata;
			out_d.out_length = pop_len_q;
			out_d.byte_valid = 1'b1;
			out_d.last       = rd_last_s1;
		end

		if (cfg.wr) begin
			stack_top_d  = '0;
			push_count_d = '0;
			push_rej_d   = 1'b0;
		end
	end

	assign out_valid_d = out_load ? 1'b1 : (result_ready ? 1'b0 : out_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_top_q  <= '0;
			push_count_q <= '0;
			push_rej_q   <= 1'b0;
			idx_q        <= '0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			stack_top_q  <= stack_top_d;
			push_count_q <= push_count_d;
			push_rej_q   <= push_rej_d;
			idx_q        <= idx_d;
			rd_valid_s1  <= rd_valid_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		limit_q    <= limit_d;
		pop_len_q  <= pop_len_d;
		base_q     <= base_d;
		rd_last_s1 <= rd_last_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/variable_record_stack.sv @@
// ----------------------------------------------------------------------------
// variable_record_stack
// Stack of variable-length records in byte memory, with an APB capacity register.
// ----------------------------------------------------------------------------
// Usage: words enter on item (valid/ready) and results leave on result
// (valid/ready). A push sends one word per record byte (one for an empty
// record); the word that ends the record gives one result, registered and
// valid in the cycle after it is taken. Other push words give no result and
// are taken one per cycle while the output is free. A pop on an empty stack
// answers in the cycle after it is taken. Otherwise the top length is read
// from the length RAM, the limit is checked, and the record streams from the
// byte RAM, one byte per cycle while the receiver takes them, and no new word
// is taken meanwhile. The byte RAM read port sets this streaming rate.
// Reset empties the stack and sets capacity to the full memory; the RAMs are
// not cleared and no entry is read before it is written.
// A stalled receiver holds the current result in the output register; while
// it is held, no new word is taken and streaming pauses without loss.
// Writing capacity_bytes (address 0) empties the stack.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_record_stack (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire vrs_pkg::item_t                    item,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output vrs_pkg::result_t                       result,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [vrs_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [vrs_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [vrs_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready
);

	vrs_pkg::cfg_t                  cfg;
	vrs_pkg::dram_req_t             dram;
	vrs_pkg::lram_req_t             lram;
	logic [vrs_pkg::BYTE_W-1:0]     dram_rdata;
	logic [vrs_pkg::LEN_W-1:0]      lram_rdata;

	vrs_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vrs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.dram         (dram),
		.dram_rdata   (dram_rdata),
		.lram         (lram),
		.lram_rdata   (lram_rdata)
	);

	// record bytes
	vrs_ram #(
		.WIDTH (vrs_pkg::BYTE_W),
		.DEPTH (vrs_pkg::MEM_BYTES)
	) u_dram (
		.clk   (clk),
		.we    (dram.we),
		.waddr (dram.waddr),
		.wdata (dram.wdata),
		.re    (dram.re),
		.raddr (dram.raddr),
		.rdata (dram_rdata)
	);

	// record lengths, one per aligned slot end
	vrs_ram #(
		.WIDTH (vrs_pkg::LEN_W),
		.DEPTH (vrs_pkg::LIDX_DEPTH)
	) u_lram (
		.clk   (clk),
		.we    (lram.we),
		.waddr (lram.waddr),
		.wdata (lram.wdata),
		.re    (lram.re),
		.raddr (lram.raddr),
		.rdata (lram_rdata)
	);

`ifndef SYNTH
	a_byte_is_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_valid |->
		result.is_pop && result.status == vrs_pkg::STATUS_OK && result.out_length != '0)
		else $error("streamed byte without a good pop");

	a_dram_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(dram.we && dram.re))
		else $error("byte RAM written and read in one cycle");

	a_lram_we_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		lram.we |-> item_valid && item_ready && item.action == vrs_pkg::ACT_PUSH)
		else $error("length written without a push word");

	a_stream_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && result.byte_valid && !result.last |=>
		result_valid && result.byte_valid)
		else $error("gap inside a popped record");
`endif

endmodule

`default_nettype wire

@@ tb/tb_variable_record_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_variable_record_stack
// Self-checking bench for the variable record stack. Directed records and
// capacity corners come first, then randomised push/pop traffic under sender
// gaps and receiver stalls, and a long receiver hold-off. Every result word is
// compared field by field against a behavioural stack kept in the bench.
// ----------------------------------------------------------------------------

module tb_variable_record_stack;
	import vrs_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_WORDS   = 32;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PRINT_LIMIT   = 100;

	localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED   = {~REG_CAPACITY, 2'b00};

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [APB_ADDR_W-1:0] paddr        = '0;
	logic [APB_DATA_W-1:0] pwdata       = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// behavioural copy of the stack
	logic [7:0]  mirror_mem [0:MEM_BYTES-1];
	int unsigned mirror_top    = 0;
	int unsigned mirror_fill   = 0;
	bit          mirror_reject = 1'b0;
	int unsigned capacity_reg  = MEM_BYTES;
	result_t     awaited_results [$];

	int error_count   = 0;
	int cycle_count   = 0;
	int words_sent    = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_off      = 1'b0;

	variable_record_stack dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		result_ready = !hold_off && ($urandom_range(99) >= stall_pct);

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h",
				cycle_count, what, got, want);
	endtask

	function automatic int unsigned record_slot(input int unsigned len);
		return (len + ALIGN_BYTES - 1 + HEADER_BYTES) & ~(ALIGN_BYTES - 1);
	endfunction

	function automatic int unsigned usable_bytes();
		return (capacity_reg < MEM_BYTES) ? capacity_reg : MEM_BYTES;
	endfunction

	function automatic bit record_fits(input int unsigned len);
		return len <= MAX_RECORD && mirror_top + record_slot(len) <= usable_bytes();
	endfunction

	function automatic result_t stack_word(input logic [1:0] status, input logic is_pop,
			input logic [7:0] data, input int unsigned len, input logic valid,
			input logic last);
		result_t r;
		r.status     = status;
		r.is_pop     = is_pop;
		r.out_byte   = data;
		r.out_length = LEN_W'(len);
		r.byte_valid = valid;
		r.last       = last;
		return r;
	endfunction

	// works out the result words one accepted word causes
	function automatic void stack_response(input item_t w);
		int unsigned len;
		int unsigned base;
		len = w.record_length;
		if (w.action == ACT_PUSH) begin
			if (mirror_fill == 0)
				mirror_reject = !record_fits(len);
			if (len != 0 && !mirror_reject && mirror_top + mirror_fill < usable_bytes())
				mirror_mem[mirror_top + mirror_fill] = w.data_byte;
			if (len != 0 && mirror_fill + 1 < len) begin
				mirror_fill = (mirror_fill + 1) & 'h7f;
				return;
			end
			mirror_fill = 0;
			// length may have changed since the first byte, so check again
			if (mirror_reject || !record_fits(len)) begin
				awaited_results.push_back(stack_word(STATUS_OVERFLOW, 1'b0, 8'h00, 0, 1'b0, 1'b1));
			end else begin
				mirror_top += record_slot(len);
				for (int i = 0; i < HEADER_BYTES; i++)
					mirror_mem[mirror_top - HEADER_BYTES + i] = (i == 0) ? len[7:0] : 8'h00;
				awaited_results.push_back(stack_word(STATUS_OK, 1'b0, 8'h00, len, 1'b0, 1'b1));
			end
			mirror_reject = 1'b0;
			return;
		end
		// pop drops any push in progress
		mirror_fill   = 0;
		mirror_reject = 1'b0;
		if (mirror_top == 0) begin
			awaited_results.push_back(stack_word(STATUS_EMPTY, 1'b1, 8'h00, 0, 1'b0, 1'b1));
			return;
		end
		len = 0;
		for (int i = 0; i < HEADER_BYTES; i++)
			len |= 32'(mirror_mem[mirror_top - HEADER_BYTES + i]) << (8 * i);
		if (len > MAX_RECORD || record_slot(len) > mirror_top) begin
			mirror_top = 0;
			awaited_results.push_back(stack_word(STATUS_EMPTY, 1'b1, 8'h00, 0, 1'b0, 1'b1));
			return;
		end
		if (w.pop_limit < MAX_RECORD && len > w.pop_limit) begin
			awaited_results.push_back(stack_word(STATUS_LIMIT, 1'b1, 8'h00, 0, 1'b0, 1'b1));
			return;
		end
		mirror_top -= record_slot(len);
		base = mirror_top;
		if (len == 0) begin
			awaited_results.push_back(stack_word(STATUS_OK, 1'b1, 8'h00, 0, 1'b0, 1'b1));
			return;
		end
		for (int i = 0; i < len; i++)
			awaited_results.push_back(stack_word(STATUS_OK, 1'b1, mirror_mem[base + i], len,
				1'b1, i == len - 1));
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result word with none awaited", result, 0);
			end else begin
				want = awaited_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
				if (result.is_pop !== want.is_pop)
					report_mismatch("is_pop", result.is_pop, want.is_pop);
				if (result.out_byte !== want.out_byte)
					report_mismatch("out_byte", result.out_byte, want.out_byte);
				if (result.out_length !== want.out_length)
					report_mismatch("out_length", result.out_length, want.out_length);
				if (result.byte_valid !== want.byte_valid)
					report_mismatch("byte_valid", result.byte_valid, want.byte_valid);
				if (result.last !== want.last)
					report_mismatch("last", result.last, want.last);
			end
		end
	end

	function automatic item_t push_word(input int unsigned len, input logic [7:0] data);
		item_t w;
		w.action        = ACT_PUSH;
		w.data_byte     = data;
		w.record_length = LEN_W'(len);
		w.pop_limit     = LEN_W'($urandom_range(127));
		return w;
	endfunction

	// unused fields of a pop carry noise
	function automatic item_t pop_word(input int unsigned limit);
		item_t w;
		w.action        = ACT_POP;
		w.data_byte     = BYTE_W'($urandom_range(255));
		w.record_length = LEN_W'($urandom_range(127));
		w.pop_limit     = LEN_W'(limit);
		return w;
	endfunction

	// called and returns at a falling edge
	task automatic send_word(input item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item       = w;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		stack_response(w);
		words_sent++;
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic push_bytes(input int count, input int unsigned len);
		repeat (count) send_word(push_word(len, BYTE_W'($urandom_range(255))));
	endtask

	task automatic push_record(input int unsigned len);
		push_bytes((len == 0) ? 1 : len, len);
	endtask

	task automatic pop_record(input int unsigned limit);
		send_word(pop_word(limit));
	endtask

	// trailing push bytes give no result, so allow the pipeline to empty too
	task automatic wait_idle();
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_register(input logic [APB_ADDR_W-1:0] addr,
			input int unsigned value);
		logic [APB_DATA_W-1:0] readback;
		wait_idle();
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = APB_DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_CAPACITY) begin
			capacity_reg  = value & ((1 << CAP_W) - 1);
			mirror_top    = 0;
			mirror_fill   = 0;
			mirror_reject = 1'b0;
		end
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = ADDR_CAPACITY;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (readback !== APB_DATA_W'(capacity_reg))
			report_mismatch("capacity readback", readback, capacity_reg);
	endtask

	task automatic test_directed_records();
		pop_record(MAX_RECORD);
		send_word(push_word(0, 8'hff));
		pop_record(MAX_RECORD);
		send_word(push_word(1, 8'h00));
		send_word(push_word(3, 8'hff));
		send_word(push_word(3, 8'h5a));
		send_word(push_word(3, 8'ha5));
		pop_record(2);
		pop_record(3);
		pop_record(0);
		pop_record(127);
		push_record(MAX_RECORD);
		pop_record(MAX_RECORD);
		// half-pushed record dropped by a pop
		push_record(2);
		push_bytes(2, 5);
		pop_record(MAX_RECORD);
		pop_record(MAX_RECORD);
		// length shrinks mid-record to the bytes sent, then one that shrinks below the bytes sent
		push_bytes(3, 6);
		push_bytes(1, 4);
		push_bytes(5, 8);
		push_bytes(1, 2);
		pop_record(MAX_RECORD);
		pop_record(MAX_RECORD);
		// oversized length rejects the record even if it later ends short
		push_bytes(1, MAX_RECORD + 6);
		push_bytes(1, 2);
		pop_record(MAX_RECORD);
	endtask

	task automatic test_capacity_limits();
		program_register(ADDR_CAPACITY, 0);
		push_record(0);
		push_record(1);
		pop_record(MAX_RECORD);
		program_register(ADDR_CAPACITY, 16);
		push_record(4);
		push_record(5);
		// starts small enough, grows past the space left
		push_bytes(2, 4);
		push_bytes(4, 6);
		push_record(4);
		push_record(0);
		pop_record(MAX_RECORD);
		pop_record(MAX_RECORD);
		pop_record(MAX_RECORD);
		program_register(ADDR_CAPACITY, 72);
		push_record(MAX_RECORD);
		push_record(0);
		pop_record(MAX_RECORD);
		program_register(ADDR_CAPACITY, (1 << CAP_W) - 1);
		push_record(9);
		push_record(17);
		program_register(ADDR_UNUSED, 'h55);
		pop_record(MAX_RECORD);
		pop_record(MAX_RECORD);
		pop_record(MAX_RECORD);
		push_record(3);
		program_register(ADDR_CAPACITY, MEM_BYTES);
		pop_record(MAX_RECORD);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_in,
			input int unsigned capacity);
		int target;
		int roll;
		int unsigned len;
		int unsigned new_len;
		int cut;
		send_idle_pct = idle_pct;
		stall_pct     = stall_in;
		program_register(ADDR_CAPACITY, capacity);
		target = words_sent + PHASE_WORDS;
		while (words_sent < target) begin
			roll = $urandom_range(99);
			if (roll < 35) begin
				pop_record(($urandom_range(3) == 0) ? $urandom_range(MAX_RECORD - 1)
					: $urandom_range(127, MAX_RECORD));
			end else begin
				roll = $urandom_range(99);
				if (roll < 2)
					len = $urandom_range(MAX_RECORD + 16, MAX_RECORD + 1);
				else if (roll < 14)
					len = $urandom_range(MAX_RECORD, 16);
				else
					len = $urandom_range(12);
				roll = $urandom_range(99);
				if (roll < 8 && len > 1) begin
					cut = $urandom_range(len - 1, 1);
					push_bytes(cut, len);
					pop_record($urandom_range(127));
				end else if (roll < 16 && len > 1) begin
					cut = $urandom_range(len - 1, 1);
					push_bytes(cut, len);
					new_len = $urandom_range(MAX_RECORD);
					push_bytes((new_len > cut) ? new_len - cut : 1, new_len);
				end else begin
					push_record(len);
				end
			end
		end
	endtask

	// receiver held off while the sender keeps offering words
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		program_register(ADDR_CAPACITY, MEM_BYTES);
		fork
			begin
				hold_off = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
		join_none
		repeat (6) push_record($urandom_range(20, 8));
		repeat (7) pop_record(MAX_RECORD);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		test_directed_records();
		test_capacity_limits();
		test_random_traffic(0, 0, MEM_BYTES);
		test_random_traffic(48, 0, 200);
		test_random_traffic(0, 48, 600);
		test_random_traffic(25, 25, (1 << CAP_W) - 1);
		test_backpressure();
		wait_idle();
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
